// ===== design/rrfs_pkg.sv =====
// Shared types and constants for the rangefinder reply frame synchronizer.
`default_nettype none
package rrfs_pkg;

  localparam int unsigned WinDepth = 8;
  localparam int unsigned FillW    = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [7:0] HdrA0    = 8'h55;
  localparam logic [7:0] HdrA1    = 8'hAA;
  localparam logic [7:0] HdrB     = 8'h5C;
  localparam logic [7:0] ByteMask = 8'hFF;

  localparam logic [FillW-1:0] FillFull   = FillW'(WinDepth);
  localparam logic [FillW-1:0] LenShortB  = 4'd4;
  localparam logic [FillW-1:0] LenLongB   = 4'd5;
  localparam logic [2:0]       LenLongCfg = 3'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFamilyB     = 3'd0,
    CfgFrameLenB   = 3'd1,
    CfgExpFunction = 3'd2,
    CfgAnyFunction = 3'd3,
    CfgOorLevel    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        family_b;
    logic [2:0]  frame_len_b;
    logic [7:0]  expected_function;
    logic        any_function;
    logic [23:0] out_of_range_level;
  } cfg_t;

  typedef struct packed {
    logic [WinDepth-1:0][7:0] bytes;
    logic [FillW-1:0]         fill;
  } win_t;

  typedef struct packed {
    logic [7:0]  function_code;
    logic [7:0]  status_code;
    logic [23:0] raw_distance;
    logic        out_of_range;
  } result_t;

endpackage
`default_nettype wire

// ===== design/rrfs_if.sv =====
// Byte and result channel interfaces with valid/ready handshake.
`default_nettype none
interface rrfs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rrfs_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  function_code;
  logic [7:0]  status_code;
  logic [23:0] raw_distance;
  logic        out_of_range;

  modport source (output valid, output function_code, output status_code,
                  output raw_distance, output out_of_range, input ready);
  modport sink   (input valid, input function_code, input status_code,
                  input raw_distance, input out_of_range, output ready);
endinterface
`default_nettype wire

// ===== design/rrfs_cfg_regs.sv =====
// Configuration register file with plain write port.
`default_nettype none
module rrfs_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rrfs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rrfs_pkg::CfgDataW-1:0] cfg_wdata_i,
  output rrfs_pkg::cfg_t                     cfg_o
);
  import rrfs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFamilyB:     cfg_d.family_b           = cfg_wdata_i[0];
        CfgFrameLenB:   cfg_d.frame_len_b        = cfg_wdata_i[2:0];
        CfgExpFunction: cfg_d.expected_function  = cfg_wdata_i[7:0];
        CfgAnyFunction: cfg_d.any_function       = cfg_wdata_i[0];
        CfgOorLevel:    cfg_d.out_of_range_level = cfg_wdata_i[23:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.family_b           <= 1'b0;
      cfg_q.frame_len_b        <= 3'd4;
      cfg_q.expected_function  <= 8'h00;
      cfg_q.any_function       <= 1'b0;
      cfg_q.out_of_range_level <= 24'h000000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== design/rrfs_window.sv =====
// Sliding byte window and fill counter, first register stage.
`default_nettype none
module rrfs_window (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       advance_i,
  input  wire logic       hit_i,
  output rrfs_pkg::win_t  win_o,
  output logic            pend_o
);
  import rrfs_pkg::*;

  logic [WinDepth-1:0][7:0] bytes_q, bytes_d;
  logic [FillW-1:0]         fill_q, fill_d, fill_base;
  logic                     pend_q, pend_d;
  logic                     consume;

  assign consume   = pend_q && advance_i;
  assign fill_base = (consume && hit_i) ? '0 : fill_q;

  always_comb begin
    bytes_d = bytes_q;
    fill_d  = fill_q;
    pend_d  = pend_q;
    if (consume) begin
      fill_d = fill_base;
      pend_d = 1'b0;
    end
    if (accept_i) begin
      for (int i = 0; i < WinDepth - 1; i++) begin
        bytes_d[i] = bytes_q[i+1];
      end
      bytes_d[WinDepth-1] = rx_byte_i;
      fill_d = (fill_base == FillFull) ? FillFull : fill_base + 1'b1;
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= '0;
      fill_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      bytes_q <= bytes_d;
      fill_q  <= fill_d;
      pend_q  <= pend_d;
    end
  end

  assign win_o.bytes = bytes_q;
  assign win_o.fill  = fill_q;
  assign pend_o      = pend_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull) else $error("fill count above window depth");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> (fill_q != '0 && pend_q)) else $error("accepted byte not counted");

  a_hit_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && hit_i && !accept_i) |=> (fill_q == '0))
    else $error("window not emptied after frame");

  a_hold_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !advance_i) |=> (pend_q && $stable(bytes_q)))
    else $error("pending window lost while stalled");

endmodule
`default_nettype wire

// ===== design/rrfs_match.sv =====
// Frame checker for both reply formats over the current window.
`default_nettype none
module rrfs_match (
  input  wire rrfs_pkg::cfg_t  cfg_i,
  input  wire rrfs_pkg::win_t  win_i,
  output logic                 hit_o,
  output rrfs_pkg::result_t    result_o
);
  import rrfs_pkg::*;

  logic [7:0]  w0, w1, w2, w3, w4, w5, w6, w7;
  logic [7:0]  sum_a, sum_b, hdr_b;
  logic [23:0] raw_b;
  logic        len5, ok_a, ok_b, func_ok, oor;
  logic [FillW-1:0] len_b;

  assign w0 = win_i.bytes[0];
  assign w1 = win_i.bytes[1];
  assign w2 = win_i.bytes[2];
  assign w3 = win_i.bytes[3];
  assign w4 = win_i.bytes[4];
  assign w5 = win_i.bytes[5];
  assign w6 = win_i.bytes[6];
  assign w7 = win_i.bytes[7];

  assign sum_a   = w0 + w1 + w2 + w3 + w4 + w5 + w6;
  assign func_ok = cfg_i.any_function || (w2 == cfg_i.expected_function);
  assign ok_a    = (win_i.fill >= FillFull) && (w0 == HdrA0) && (w1 == HdrA1)
                   && (sum_a == w7) && func_ok;

  assign len5  = (cfg_i.frame_len_b >= LenLongCfg);
  assign len_b = len5 ? LenLongB : LenShortB;
  assign hdr_b = len5 ? w3 : w4;
  assign sum_b = len5 ? (w4 + w5 + w6) : (w5 + w6);
  assign raw_b = len5 ? {w6, w5, w4} : {8'h00, w6, w5};
  assign ok_b  = (win_i.fill >= len_b) && (hdr_b == HdrB)
                 && ((sum_b ^ ByteMask) == w7);
  assign oor   = (cfg_i.out_of_range_level != '0)
                 && (raw_b >= cfg_i.out_of_range_level);

  always_comb begin
    if (cfg_i.family_b) begin
      hit_o                  = ok_b;
      result_o.function_code = 8'h00;
      result_o.status_code   = 8'h01;
      result_o.raw_distance  = raw_b;
      result_o.out_of_range  = oor;
    end else begin
      hit_o                  = ok_a;
      result_o.function_code = w2;
      result_o.status_code   = w3;
      result_o.raw_distance  = {8'h00, w5, w6};
      result_o.out_of_range  = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== design/rrfs_out_reg.sv =====
// Result register stage driving the result channel.
`default_nettype none
module rrfs_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire rrfs_pkg::result_t  result_i,
  input  wire logic               ready_i,
  output logic                    free_o,
  output logic                    valid_o,
  output rrfs_pkg::result_t       result_o
);
  import rrfs_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

// ===== design/rangefinder_reply_frame_sync.sv =====
// Top level of the rangefinder reply frame synchronizer.
//
// Usage: received serial bytes enter on rx_i, one per transfer. The block
// keeps the eight newest bytes and checks them after each byte against the
// selected reply format (55 AA eight-byte frames, or 5C frames of four or
// five bytes). A valid frame yields one transfer on res_o and empties the
// window; other bytes yield nothing.
// The frame's result passes the window register, then the result register.
// Throughput: one byte per cycle while res_o does not stall, set by the
// single window register stage. Reset clears the window, the fill count,
// the result valid flag and all configuration registers to their defaults.
// When res_o stalls, the finished result holds in the result register and
// one further byte is still taken into the window; rx_i.ready drops only
// once that window waits for a free result register. Configuration is
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i by the user only while
// idle; the block itself does not enforce this.
`default_nettype none
module rangefinder_reply_frame_sync (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rrfs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rrfs_pkg::CfgDataW-1:0] cfg_wdata_i,
  rrfs_byte_if.sink                          rx_i,
  rrfs_result_if.source                      res_o
);
  import rrfs_pkg::*;

  cfg_t    cfg;
  win_t    win;
  result_t match_res, out_res;
  logic    pend, hit, free, accept, out_valid;

  assign rx_i.ready = !pend || free;
  assign accept     = rx_i.valid && rx_i.ready;

  rrfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rrfs_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .advance_i (free),
    .hit_i     (hit),
    .win_o     (win),
    .pend_o    (pend)
  );

  rrfs_match u_match (
    .cfg_i    (cfg),
    .win_i    (win),
    .hit_o    (hit),
    .result_o (match_res)
  );

  rrfs_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (pend && hit),
    .result_i (match_res),
    .ready_i  (res_o.ready),
    .free_o   (free),
    .valid_o  (out_valid),
    .result_o (out_res)
  );

  assign res_o.valid         = out_valid;
  assign res_o.function_code = out_res.function_code;
  assign res_o.status_code   = out_res.status_code;
  assign res_o.raw_distance  = out_res.raw_distance;
  assign res_o.out_of_range  = out_res.out_of_range;

endmodule
`default_nettype wire
